### rtl/i2cms_pkg.sv
package i2cms_pkg;

	localparam int BUF_DEPTH_DEF = 256;

	typedef enum logic [1:0] {
		CMD_BEGIN   = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_STATUS  = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_BUSY  = 2'd1,
		PH_DONE  = 2'd2,
		PH_ERROR = 2'd3
	} phase_t;

	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_RESTART      = 8'h10;
	localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
	localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
	localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
	localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
	localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
	localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

	localparam logic [7:0] READ_BIT = 8'h01;

	localparam logic [1:0] START_KEEP = 2'd0;
	localparam logic [1:0] START_SET  = 2'd1;
	localparam logic [1:0] START_CLR  = 2'd2;

	localparam logic [1:0] ACK_KEEP     = 2'd0;
	localparam logic [1:0] ACK_ASSERT   = 2'd1;
	localparam logic [1:0] ACK_WITHDRAW = 2'd2;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} buf_ctrl_t;

	typedef struct packed {
		logic       data_write;
		logic [7:0] data_value;
		logic [1:0] start_ctrl;
		logic       stop_request;
		logic [1:0] ack_ctrl;
		logic [1:0] xfer_state;
		logic [7:0] byte_count;
		logic       rx_valid;
		logic [7:0] rx_index;
		logic [7:0] rx_byte;
	} result_t;

endpackage

### rtl/i2cms_buf.sv
module i2cms_buf #(
	parameter int DEPTH = i2cms_pkg::BUF_DEPTH_DEF,
	parameter int AW    = 8
) (
	input  logic                  clk,
	input  i2cms_pkg::buf_ctrl_t  ctrl,
	input  logic [AW-1:0]         waddr,
	input  logic [7:0]            wdata,
	input  logic [AW-1:0]         raddr,
	output logic [7:0]            rdata
);
	import i2cms_pkg::*;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read so a stalled beat keeps its byte
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/i2c_master_transfer_sequencer_core.sv
// I2C master transfer sequencer. Takes one item per clock unless stalled
// (begin, buffer load, bus status event, release) and returns exactly one
// result beat per item, in the cycle after acceptance; throughput is one item
// per cycle with no stall on the output side. The synchronous read port of
// the transmit buffer is read in the accept cycle and delivers the
// byte with the result beat. Buffer contents are undefined after reset and
// must be loaded before they are transmitted; the scalar transfer state
// (phase, address byte, position, length) resets to idle and zero.
module i2c_master_transfer_sequencer_core #(
	parameter int BUFFER_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic       is_read,
	input  logic [7:0] slave_address,
	input  logic [7:0] transfer_len,
	input  logic [7:0] load_index,
	input  logic [7:0] load_byte,
	input  logic [7:0] bus_status,
	input  logic [7:0] bus_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       data_write,
	output logic [7:0] data_value,
	output logic [1:0] start_ctrl,
	output logic       stop_request,
	output logic [1:0] ack_ctrl,
	output logic [1:0] xfer_state,
	output logic [7:0] byte_count,
	output logic       rx_valid,
	output logic [7:0] rx_index,
	output logic [7:0] rx_byte
);
	import i2cms_pkg::*;

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	// position and load index wrap at the buffer depth
	function automatic logic [255:0][AW-1:0] wrap_table();
		logic [255:0][AW-1:0] t;
		int r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			t[i] = AW'(r);
			r = (r == BUFFER_DEPTH - 1) ? 0 : r + 1;
		end
		return t;
	endfunction

	localparam logic [255:0][AW-1:0] WRAP_TAB = wrap_table();

	phase_t     phase_q, phase_d;
	logic [7:0] addr_q;
	logic [7:0] pos_q, pos_d;
	logic [7:0] len_q;

	logic       accept;
	cmd_t       cmd_c;
	logic       room;
	logic       room_next;
	logic [7:0] pos_inc;
	logic       from_mem;
	result_t    res;

	logic       valid_s2;
	logic       from_mem_s2;
	result_t    res_s2;

	buf_ctrl_t  buf_ctrl;
	logic [7:0] buf_rdata;

	assign in_stall  = valid_s2 & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign cmd_c     = cmd_t'(cmd);
	assign room      = pos_q < len_q;
	assign pos_inc   = pos_q + 8'd1;
	assign room_next = pos_inc < len_q;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		case (cmd_c)
			CMD_BEGIN: begin
				if (phase_q != PH_BUSY) begin
					phase_d = PH_BUSY;
					pos_d   = 8'd0;
				end
			end
			CMD_RELEASE: begin
				phase_d = PH_IDLE;
			end
			CMD_STATUS: begin
				if (phase_q == PH_BUSY) begin
					case (bus_status)
						ST_START, ST_RESTART, ST_MR_SLA_ACK: begin
						end
						ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
							if (room) begin
								pos_d = pos_inc;
							end else begin
								phase_d = PH_DONE;
							end
						end
						ST_MR_SLA_NACK: begin
							phase_d = PH_DONE;
						end
						ST_MR_DATA_ACK: begin
							if (room) begin
								pos_d = pos_inc;
							end else begin
								phase_d = PH_ERROR;
							end
						end
						ST_MR_DATA_NACK: begin
							if (room) begin
								pos_d = pos_inc;
							end
							phase_d = PH_DONE;
						end
						default: begin
							phase_d = PH_ERROR;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res      = '0;
		from_mem = 1'b0;
		case (cmd_c)
			CMD_BEGIN: begin
				if (phase_q != PH_BUSY) begin
					res.ack_ctrl   = ACK_WITHDRAW;
					res.start_ctrl = START_SET;
				end
			end
			CMD_STATUS: begin
				if (phase_q == PH_BUSY) begin
					case (bus_status)
						ST_START, ST_RESTART: begin
							res.data_write = 1'b1;
							res.data_value = addr_q;
							res.start_ctrl = START_CLR;
						end
						ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
							if (room) begin
								res.data_write = 1'b1;
								from_mem       = 1'b1;
							end else begin
								res.stop_request = 1'b1;
							end
						end
						ST_MT_SLA_NACK, ST_MR_SLA_NACK: begin
							res.stop_request = 1'b1;
						end
						ST_MR_SLA_ACK: begin
							res.ack_ctrl = room ? ACK_ASSERT : ACK_WITHDRAW;
						end
						ST_MR_DATA_ACK: begin
							if (room) begin
								res.rx_valid = 1'b1;
								res.rx_index = pos_q;
								res.rx_byte  = bus_byte;
								res.ack_ctrl = room_next ? ACK_ASSERT : ACK_WITHDRAW;
							end else begin
								res.stop_request = 1'b1;
							end
						end
						ST_MR_DATA_NACK: begin
							if (room) begin
								res.rx_valid = 1'b1;
								res.rx_index = pos_q;
								res.rx_byte  = bus_byte;
							end
							res.stop_request = 1'b1;
						end
						default: begin
							res.ack_ctrl     = ACK_WITHDRAW;
							res.stop_request = 1'b1;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		res.xfer_state = phase_d;
		res.byte_count = pos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= '0;
			pos_q   <= '0;
			len_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			if (cmd_c == CMD_BEGIN && phase_q != PH_BUSY) begin
				addr_q <= is_read ? (slave_address | READ_BIT) : slave_address;
				len_q  <= transfer_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (accept) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s2      <= res;
			from_mem_s2 <= from_mem;
		end
	end

	assign buf_ctrl.wr_en = accept & (cmd_c == CMD_LOAD);
	assign buf_ctrl.rd_en = accept;

	i2cms_buf #(
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_buf (
		.clk   (clk),
		.ctrl  (buf_ctrl),
		.waddr (WRAP_TAB[load_index]),
		.wdata (load_byte),
		.raddr (WRAP_TAB[pos_q]),
		.rdata (buf_rdata)
	);

	assign out_valid    = valid_s2;
	assign data_write   = res_s2.data_write;
	assign data_value   = from_mem_s2 ? buf_rdata : res_s2.data_value;
	assign start_ctrl   = res_s2.start_ctrl;
	assign stop_request = res_s2.stop_request;
	assign ack_ctrl     = res_s2.ack_ctrl;
	assign xfer_state   = res_s2.xfer_state;
	assign byte_count   = res_s2.byte_count;
	assign rx_valid     = res_s2.rx_valid;
	assign rx_index     = res_s2.rx_index;
	assign rx_byte      = res_s2.rx_byte;

endmodule

### rtl/i2cms_chk.sv
module i2cms_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] cmd,
	input logic       out_valid,
	input logic       out_stall,
	input logic       data_write,
	input logic [7:0] data_value,
	input logic       rx_valid,
	input logic [7:0] rx_index,
	input logic [7:0] rx_byte
);
	import i2cms_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_in_beat_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted beat gave no result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output stage");

	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rx_valid |-> rx_index == 8'd0 && rx_byte == 8'd0)
		else $error("receive fields set without a received byte");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_LOAD |=> !data_write && data_value == 8'd0)
		else $error("buffer load produced bus data");

endmodule

bind i2c_master_transfer_sequencer_core i2cms_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.cmd        (cmd),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.data_write (data_write),
	.data_value (data_value),
	.rx_valid   (rx_valid),
	.rx_index   (rx_index),
	.rx_byte    (rx_byte)
);

### tb/sv/i2c_master_transfer_sequencer_core_tb.sv
`timescale 1ns / 100ps

import i2cms_pkg::*;

class xfer_predictor;
	phase_t     phase;
	logic [7:0] addr_byte;
	logic [7:0] position;
	logic [7:0] length;
	logic [7:0] tx_buf [256];
	bit         loaded [256];
	result_t    pending [$];
	int         mismatches;
	int         beats;

	function new();
		phase      = PH_IDLE;
		addr_byte  = '0;
		position   = '0;
		length     = '0;
		mismatches = 0;
		beats      = 0;
		foreach (loaded[i]) loaded[i] = 1'b0;
	endfunction

	// a transmit read of a never-loaded entry is off limits
	function bit needs_load(logic [7:0] st);
		return phase == PH_BUSY && (st == ST_MT_SLA_ACK || st == ST_MT_DATA_ACK) &&
			position < length && !loaded[position];
	endfunction

	function void note_item(cmd_t c, bit rd, logic [7:0] sla, logic [7:0] tlen,
		logic [7:0] lidx, logic [7:0] lbyte, logic [7:0] st, logic [7:0] bb);
		result_t r;
		r = '0;
		case (c)
			CMD_BEGIN: begin
				if (phase != PH_BUSY) begin
					phase     = PH_BUSY;
					addr_byte = rd ? (sla | READ_BIT) : sla;
					position  = '0;
					length    = tlen;
					r.ack_ctrl   = ACK_WITHDRAW;
					r.start_ctrl = START_SET;
				end
			end
			CMD_LOAD: begin
				tx_buf[lidx] = lbyte;
				loaded[lidx] = 1'b1;
			end
			CMD_RELEASE: begin
				phase = PH_IDLE;
			end
			default: begin
				if (phase == PH_BUSY) begin
					case (st)
						ST_START, ST_RESTART: begin
							r.data_write = 1'b1;
							r.data_value = addr_byte;
							r.start_ctrl = START_CLR;
						end
						ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
							if (position < length) begin
								r.data_write = 1'b1;
								r.data_value = tx_buf[position];
								position++;
							end else begin
								r.stop_request = 1'b1;
								phase = PH_DONE;
							end
						end
						ST_MT_SLA_NACK: begin
							r.stop_request = 1'b1;
							phase = PH_ERROR;
						end
						ST_MR_SLA_ACK: begin
							r.ack_ctrl = (position < length) ? ACK_ASSERT : ACK_WITHDRAW;
						end
						ST_MR_SLA_NACK: begin
							r.stop_request = 1'b1;
							phase = PH_DONE;
						end
						ST_MR_DATA_ACK: begin
							if (position < length) begin
								r.rx_valid = 1'b1;
								r.rx_index = position;
								r.rx_byte  = bb;
								position++;
								r.ack_ctrl = (position < length) ? ACK_ASSERT : ACK_WITHDRAW;
							end else begin
								r.stop_request = 1'b1;
								phase = PH_ERROR;
							end
						end
						ST_MR_DATA_NACK: begin
							if (position < length) begin
								r.rx_valid = 1'b1;
								r.rx_index = position;
								r.rx_byte  = bb;
								position++;
							end
							r.stop_request = 1'b1;
							phase = PH_DONE;
						end
						default: begin
							r.ack_ctrl     = ACK_WITHDRAW;
							r.stop_request = 1'b1;
							phase = PH_ERROR;
						end
					endcase
				end
			end
		endcase
		r.xfer_state = phase;
		r.byte_count = position;
		pending.push_back(r);
	endfunction

	function string fmt(result_t r);
		return $sformatf("dw=%0b dv=%02h sc=%0d stop=%0b ack=%0d st=%0d cnt=%0d rx=%0b/%0d/%02h",
			r.data_write, r.data_value, r.start_ctrl, r.stop_request, r.ack_ctrl,
			r.xfer_state, r.byte_count, r.rx_valid, r.rx_index, r.rx_byte);
	endfunction

	function void report(string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endfunction

	function void check_beat(result_t got);
		result_t want;
		beats++;
		if (pending.size() == 0) begin
			report($sformatf("beat %0d with nothing pending: %s", beats, fmt(got)));
			return;
		end
		want = pending.pop_front();
		if (got.data_write !== want.data_write || got.data_value !== want.data_value ||
			got.start_ctrl !== want.start_ctrl || got.stop_request !== want.stop_request ||
			got.ack_ctrl !== want.ack_ctrl || got.xfer_state !== want.xfer_state ||
			got.byte_count !== want.byte_count || got.rx_valid !== want.rx_valid ||
			got.rx_index !== want.rx_index || got.rx_byte !== want.rx_byte)
			report($sformatf("beat %0d mismatch: exp %s got %s", beats, fmt(want), fmt(got)));
	endfunction
endclass

module i2c_master_transfer_sequencer_core_tb;

	localparam int RANDOM_ITEMS = 900;
	localparam int CYCLE_LIMIT  = 500000;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       out_stall     = 1'b0;
	logic [1:0] cmd           = CMD_RELEASE;
	logic       is_read       = 1'b0;
	logic [7:0] slave_address = '0;
	logic [7:0] transfer_len  = '0;
	logic [7:0] load_index    = '0;
	logic [7:0] load_byte     = '0;
	logic [7:0] bus_status    = '0;
	logic [7:0] bus_byte      = '0;

	logic       in_stall;
	logic       out_valid;
	logic       data_write;
	logic [7:0] data_value;
	logic [1:0] start_ctrl;
	logic       stop_request;
	logic [1:0] ack_ctrl;
	logic [1:0] xfer_state;
	logic [7:0] byte_count;
	logic       rx_valid;
	logic [7:0] rx_index;
	logic [7:0] rx_byte;

	xfer_predictor pred = new();
	int items_sent = 0;
	int cycles     = 0;
	bit send_calm  = 1'b0;
	bit recv_calm  = 1'b0;

	i2c_master_transfer_sequencer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.is_read      (is_read),
		.slave_address(slave_address),
		.transfer_len (transfer_len),
		.load_index   (load_index),
		.load_byte    (load_byte),
		.bus_status   (bus_status),
		.bus_byte     (bus_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_write   (data_write),
		.data_value   (data_value),
		.start_ctrl   (start_ctrl),
		.stop_request (stop_request),
		.ack_ctrl     (ack_ctrl),
		.xfer_state   (xfer_state),
		.byte_count   (byte_count),
		.rx_valid     (rx_valid),
		.rx_index     (rx_index),
		.rx_byte      (rx_byte)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 29) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic bit rnd1();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [7:0] pick_status();
		logic [7:0] codes [9];
		codes = '{ST_START, ST_RESTART, ST_MT_SLA_ACK, ST_MT_SLA_NACK, ST_MT_DATA_ACK,
			ST_MR_SLA_ACK, ST_MR_SLA_NACK, ST_MR_DATA_ACK, ST_MR_DATA_NACK};
		if ($urandom_range(0, 3) == 0) return rnd8();
		return codes[$urandom_range(0, 8)];
	endfunction

	task automatic send_item(cmd_t c, bit rd, logic [7:0] sla, logic [7:0] tlen,
		logic [7:0] lidx, logic [7:0] lbyte, logic [7:0] st, logic [7:0] bb);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		is_read       <= rd;
		slave_address <= sla;
		transfer_len  <= tlen;
		load_index    <= lidx;
		load_byte     <= lbyte;
		bus_status    <= st;
		bus_byte      <= bb;
		do @(posedge clk); while (in_stall);
		pred.note_item(c, rd, sla, tlen, lidx, lbyte, st, bb);
		items_sent++;
	endtask

	task automatic do_begin(bit rd, logic [7:0] sla, logic [7:0] tlen);
		send_item(CMD_BEGIN, rd, sla, tlen, rnd8(), rnd8(), rnd8(), rnd8());
	endtask

	task automatic do_load(logic [7:0] idx, logic [7:0] b);
		send_item(CMD_LOAD, rnd1(), rnd8(), rnd8(), idx, b, rnd8(), rnd8());
	endtask

	task automatic do_status(logic [7:0] st, logic [7:0] bb);
		if (pred.needs_load(st)) do_load(pred.position, rnd8());
		send_item(CMD_STATUS, rnd1(), rnd8(), rnd8(), rnd8(), rnd8(), st, bb);
	endtask

	task automatic do_release();
		send_item(CMD_RELEASE, rnd1(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
	endtask

	task automatic noise_burst();
		cmd_t c;
		repeat ($urandom_range(1, 4)) begin
			c = cmd_t'($urandom_range(0, 3));
			if (c == CMD_STATUS)
				do_status(pick_status(), rnd8());
			else
				send_item(c, rnd1(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
		end
	endtask

	task automatic run_transaction(bit go_long);
		bit         rd;
		bit         flip;
		logic [7:0] len;
		int         limit;
		int         k;
		rd    = go_long ? 1'b1 : rnd1();
		len   = go_long ? 8'd255 :
			($urandom_range(0, 15) == 0) ? rnd8() : 8'($urandom_range(0, 6));
		limit = go_long ? 300 : 12;
		if (!rd)
			for (k = 0; k < len && k < 8; k++)
				if (rnd1()) do_load(8'(k), rnd8());
		do_begin(rd, rnd8(), len);
		do_status(($urandom_range(0, 7) == 0) ? ST_RESTART : ST_START, rnd8());
		if (rd)
			do_status((!go_long && $urandom_range(0, 7) == 0) ? ST_MR_SLA_NACK : ST_MR_SLA_ACK,
				rnd8());
		else
			do_status(($urandom_range(0, 7) == 0) ? ST_MT_SLA_NACK : ST_MT_SLA_ACK, rnd8());
		for (k = 0; k < limit && pred.phase == PH_BUSY; k++) begin
			flip = !go_long && $urandom_range(0, 9) == 0;
			if (!go_long && $urandom_range(0, 11) == 0)
				do_status(pick_status(), rnd8());
			else if (!rd)
				do_status(ST_MT_DATA_ACK, rnd8());
			else if ((pred.position + 1 < pred.length) != flip)
				do_status(ST_MR_DATA_ACK, rnd8());
			else
				do_status(ST_MR_DATA_NACK, rnd8());
		end
		if ($urandom_range(0, 7) != 0) do_release();
	endtask

	// result side: random stall after each beat
	initial begin
		int      stall_left;
		result_t got;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = {data_write, data_value, start_ctrl, stop_request, ack_ctrl,
					xfer_state, byte_count, rx_valid, rx_index, rx_byte};
				pred.check_beat(got);
				stall_left = draw_wait(recv_calm);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0);
		end
	end

	initial begin
		int goal;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		do_release();
		do_status(ST_START, 8'h00);
		do_load(8'h00, 8'hFF);
		do_load(8'hFF, 8'h00);
		do_load(8'h01, 8'h5A);
		do_begin(1'b0, 8'hFF, 8'd2);
		do_begin(1'b1, 8'h00, 8'd9);
		do_status(ST_START, 8'hFF);
		do_status(ST_MT_SLA_ACK, 8'h00);
		do_status(ST_MT_DATA_ACK, 8'h11);
		do_status(ST_MT_DATA_ACK, 8'h22);
		do_begin(1'b1, 8'h00, 8'd1);
		do_status(ST_RESTART, 8'hAA);
		do_status(ST_MR_SLA_ACK, 8'h55);
		do_status(ST_MR_DATA_ACK, 8'hFF);
		do_status(ST_MR_DATA_ACK, 8'h00);
		do_begin(1'b1, 8'hFE, 8'd0);
		do_status(ST_MR_SLA_ACK, 8'h00);
		do_status(ST_MR_DATA_NACK, 8'h3C);
		do_begin(1'b0, 8'h80, 8'd255);
		do_status(ST_MT_SLA_NACK, 8'h00);
		do_begin(1'b1, 8'h7F, 8'd2);
		do_status(ST_MR_SLA_NACK, 8'h00);
		do_begin(1'b1, 8'h12, 8'd2);
		do_status(ST_MR_DATA_NACK, 8'hC3);
		do_begin(1'b0, 8'h34, 8'd1);
		do_status(8'hFF, 8'h00);
		do_begin(1'b0, 8'h56, 8'd3);
		do_release();

		goal = items_sent + RANDOM_ITEMS;
		run_transaction(1'b1);
		while (items_sent < goal) begin
			if ($urandom_range(0, 5) == 0)
				noise_burst();
			else
				run_transaction(1'b0);
		end

		in_valid <= 1'b0;
		while (pred.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pred.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
